// ===== hw/rtl/nge_pkg.sv =====
`timescale 1ns / 1ps

package nge_pkg;

  localparam int FRACTION_BITS = 23;
  localparam int LW = FRACTION_BITS + 1;
  localparam int REG_W = 24;
  localparam int WW = (LW > REG_W) ? LW : REG_W;
  localparam int NOTE_W = 7;
  localparam int VEL_W = 7;
  localparam int IDX_W = 3;

  localparam longint unsigned ONE_L = 64'd1 << FRACTION_BITS;
  localparam logic [LW-1:0] ONE = LW'(ONE_L);
  localparam logic [LW-1:0] HALF = LW'(ONE_L >> 1);
  localparam logic [LW-1:0] ATTACK_SNAP = LW'((999 * ONE_L + 500) / 1000);
  localparam logic [LW-1:0] DECAY_EPS = LW'((5 * ONE_L + 5000) / 10000);
  localparam logic [LW-1:0] RELEASE_SNAP = LW'((5 * ONE_L + 50000) / 100000);

  localparam logic [REG_W-1:0] ATTACK_RST = 24'd58050;
  localparam logic [REG_W-1:0] DECAY_RST = 24'd336;
  localparam logic [REG_W-1:0] SUSTAIN_RST = 24'd6039798;
  localparam logic [REG_W-1:0] RELEASE_RST = 24'd184;
  localparam logic [REG_W-1:0] VEL_AMOUNT_RST = 24'd5872026;
  localparam logic [NOTE_W-1:0] HELD_NOTE_RST = 7'd60;

  // velocity amount split as amt = 127 * q + r, with r pre-scaled by the
  // reciprocal of 127 so that note on needs no divider
  localparam int AMT_W = REG_W;
  localparam int AQ_W = 18;
  localparam int AR_W = 7;
  localparam int RR_W = 21;
  localparam int BIG_SHIFT = 31;
  localparam int SMALL_SHIFT = 21;
  localparam int RB_W = 25;
  localparam int RS_W = 15;
  localparam longint unsigned RECIP_BIG_L = ((64'd1 << BIG_SHIFT) + 126) / 127;
  localparam longint unsigned RECIP_SMALL_L = ((64'd1 << SMALL_SHIFT) + 126) / 127;
  localparam logic [RB_W-1:0] RECIP_BIG = RB_W'(RECIP_BIG_L);
  localparam logic [RS_W-1:0] RECIP_SMALL = RS_W'(RECIP_SMALL_L);
  localparam logic [RR_W+1:0] ROUND_SMALL = (RR_W + 2)'(63 * RECIP_SMALL_L);

  localparam longint unsigned AMT_RST_L =
    (64'(VEL_AMOUNT_RST) > ONE_L) ? ONE_L : 64'(VEL_AMOUNT_RST);
  localparam logic [AMT_W-1:0] AMT_RST = AMT_W'(AMT_RST_L);
  localparam logic [AQ_W-1:0] AMT_Q_RST = AQ_W'(AMT_RST_L / 127);
  localparam logic [RR_W-1:0] AMT_RR_RST = RR_W'((AMT_RST_L % 127) * RECIP_SMALL_L);

  localparam logic [IDX_W-1:0] CFG_ATTACK = 3'd0;
  localparam logic [IDX_W-1:0] CFG_DECAY = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [IDX_W-1:0] CFG_VEL_AMOUNT = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_ATTACK = 3'd1,
    ST_DECAY = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_ALL_OFF = 2'd3
  } op_t;

  typedef struct packed {
    stage_t stage;
    logic [LW-1:0] level;
    logic [NOTE_W-1:0] held_note;
    logic [LW-1:0] gain;
  } env_t;

  typedef struct packed {
    logic [LW-1:0] atk_rate;
    logic [LW-1:0] dcy_rate;
    logic [LW-1:0] sus_level;
    logic [LW-1:0] rls_rate;
    logic [AMT_W-1:0] amt;
    logic [AQ_W-1:0] amt_q;
    logic [RR_W-1:0] amt_rr;
  } coef_t;

  function automatic logic [LW-1:0] sat_one(input logic [REG_W-1:0] v);
    logic [WW-1:0] w;
    w = WW'(v);
    return (w > WW'(ONE)) ? ONE : LW'(w);
  endfunction

endpackage

// ===== hw/rtl/note_gated_adsr_envelope.sv =====
// path: an accepted word waits in the input register, then moves on to the
// result register when that is empty or being taken, and is offered there
// throughput: one word per cycle; the input register refills while the
// result register is taken, so only a stalled output holds off input
// reset: synchronous, active high; stage idle, level zero, held note 60,
// gain 1.0, registers at their defaults; nothing pending on either side
`timescale 1ns / 1ps

module note_gated_adsr_envelope import nge_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [NOTE_W-1:0] note_number,
  input  logic [VEL_W-1:0]  velocity,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [REG_W-1:0]  level,
  output logic [2:0]        stage,
  output logic [REG_W-1:0]  gain
);

  coef_t coef;
  env_t  env;
  env_t  env_next;

  logic              in_full;
  logic [1:0]        op_q;
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;
  logic              advance;

  logic [AMT_W-1:0]      amt_w;
  logic [AMT_W+RB_W-1:0] amt_big;
  logic [AQ_W-1:0]       amt_q_w;
  logic [AMT_W-1:0]      amt_r_full;
  logic [AR_W-1:0]       amt_r_w;
  logic [RR_W-1:0]       amt_rr_w;

  // velocity amount split at write time
  assign amt_w      = AMT_W'(sat_one(cfg_data));
  assign amt_big    = (AMT_W + RB_W)'(amt_w) * (AMT_W + RB_W)'(RECIP_BIG);
  assign amt_q_w    = AQ_W'(amt_big >> BIG_SHIFT);
  assign amt_r_full = amt_w - (AMT_W'(amt_q_w) << 7) + AMT_W'(amt_q_w);
  assign amt_r_w    = AR_W'(amt_r_full);
  assign amt_rr_w   = RR_W'(amt_r_w) * RR_W'(RECIP_SMALL);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.atk_rate  <= sat_one(ATTACK_RST);
      coef.dcy_rate  <= sat_one(DECAY_RST);
      coef.sus_level <= sat_one(SUSTAIN_RST);
      coef.rls_rate  <= sat_one(RELEASE_RST);
      coef.amt       <= AMT_RST;
      coef.amt_q     <= AMT_Q_RST;
      coef.amt_rr    <= AMT_RR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK:  coef.atk_rate  <= sat_one(cfg_data);
        CFG_DECAY:   coef.dcy_rate  <= sat_one(cfg_data);
        CFG_SUSTAIN: coef.sus_level <= sat_one(cfg_data);
        CFG_RELEASE: coef.rls_rate  <= sat_one(cfg_data);
        CFG_VEL_AMOUNT: begin
          coef.amt    <= amt_w;
          coef.amt_q  <= amt_q_w;
          coef.amt_rr <= amt_rr_w;
        end
        default: ;
      endcase
    end
  end

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= opcode;
      note_q <= note_number;
      vel_q  <= velocity;
    end
  end

  nge_step u_step (
    .cur  (env),
    .coef (coef),
    .op   (op_t'(op_q)),
    .note (note_q),
    .vel  (vel_q),
    .nxt  (env_next)
  );

  // envelope state doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      env.stage     <= ST_IDLE;
      env.level     <= '0;
      env.held_note <= HELD_NOTE_RST;
      env.gain      <= ONE;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        env       <= env_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign level = REG_W'(env.level);
  assign stage = env.stage;
  assign gain  = REG_W'(env.gain);

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && env.stage == ST_IDLE) |-> env.level == '0)
    else $error("idle envelope with nonzero level");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    env.level <= ONE)
    else $error("envelope level above one");

  a_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> in_full)
    else $error("accepted word not held in input register");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (in_full && !out_valid) |=> out_valid)
    else $error("pending word did not reach the result register");

endmodule

// ===== hw/rtl/nge_step.sv =====
`timescale 1ns / 1ps

module nge_step import nge_pkg::*; (
  input  env_t              cur,
  input  coef_t             coef,
  input  op_t               op,
  input  logic [NOTE_W-1:0] note,
  input  logic [VEL_W-1:0]  vel,
  output env_t              nxt
);

  localparam int GW = WW + 2;
  localparam int PW = 2 * LW;

  logic              above;
  logic [LW-1:0]     span;
  logic [LW-1:0]     step;
  logic [PW-1:0]     prod;
  logic [LW-1:0]     sc;
  logic [LW:0]       up;
  logic [LW-1:0]     down;
  logic [LW-1:0]     gap;
  logic [LW:0]       dec_lvl;
  stage_t            tick_stage;
  logic [LW-1:0]     tick_level;

  logic [AQ_W+VEL_W-1:0]  gprod_q;
  logic [RR_W+VEL_W:0]    gprod_r;
  logic [AR_W-1:0]        gfrac;
  logic [GW-1:0]          gsum;
  logic [LW-1:0]          new_gain;
  logic                   off_hit;

  function automatic logic [LW-1:0] clamp_one(input logic [LW:0] x);
    return (x > (LW + 1)'(ONE)) ? ONE : LW'(x);
  endfunction

  // approach step: one shared multiplier picks distance and rate by stage
  always_comb begin
    above = cur.level > coef.sus_level;
    case (cur.stage)
      ST_ATTACK: begin
        span = ONE - cur.level;
        step = coef.atk_rate;
      end
      ST_DECAY: begin
        span = above ? cur.level - coef.sus_level : coef.sus_level - cur.level;
        step = coef.dcy_rate;
      end
      default: begin
        span = cur.level;
        step = coef.rls_rate;
      end
    endcase
  end

  assign prod = PW'(span) * PW'(step);
  assign sc   = LW'((prod + PW'(HALF)) >> FRACTION_BITS);
  assign up   = (LW + 1)'(cur.level) + (LW + 1)'(sc);
  assign down = cur.level - sc;
  assign gap  = span - sc;
  assign dec_lvl = above ? (LW + 1)'(down) : up;

  always_comb begin
    tick_stage = cur.stage;
    tick_level = cur.level;
    case (cur.stage)
      ST_ATTACK: begin
        if (up >= (LW + 1)'(ATTACK_SNAP)) begin
          tick_level = ONE;
          tick_stage = ST_DECAY;
        end else begin
          tick_level = clamp_one(up);
        end
      end
      ST_DECAY: begin
        if (gap < DECAY_EPS) begin
          tick_level = coef.sus_level;
          tick_stage = ST_SUSTAIN;
        end else begin
          tick_level = clamp_one(dec_lvl);
        end
      end
      ST_SUSTAIN: begin
        tick_level = coef.sus_level;
      end
      ST_RELEASE: begin
        if (down <= RELEASE_SNAP) begin
          tick_level = '0;
          tick_stage = ST_IDLE;
        end else begin
          tick_level = down;
        end
      end
      default: begin
        tick_level = '0;
        tick_stage = ST_IDLE;
      end
    endcase
  end

  // gain = one - amt + round(vel * amt / 127), with amt = 127 * q + r
  assign gprod_q = (AQ_W + VEL_W)'(vel) * (AQ_W + VEL_W)'(coef.amt_q);
  assign gprod_r = (RR_W + VEL_W + 1)'(vel) * (RR_W + VEL_W + 1)'(coef.amt_rr)
                 + (RR_W + VEL_W + 1)'(ROUND_SMALL);
  assign gfrac   = AR_W'(gprod_r >> SMALL_SHIFT);
  assign gsum    = GW'(ONE) + GW'(gprod_q) + GW'(gfrac) - GW'(coef.amt);
  assign new_gain = (gsum > GW'(ONE)) ? ONE : LW'(gsum);

  assign off_hit = (note == cur.held_note) && (cur.stage != ST_IDLE);

  always_comb begin
    nxt = cur;
    case (op)
      OP_TICK: begin
        nxt.stage = tick_stage;
        nxt.level = tick_level;
      end
      OP_NOTE_ON: begin
        if (vel == '0) begin
          if (off_hit) begin
            nxt.stage = ST_RELEASE;
          end
        end else begin
          nxt.held_note = note;
          nxt.gain = new_gain;
          nxt.stage = ST_ATTACK;
        end
      end
      OP_NOTE_OFF: begin
        if (off_hit) begin
          nxt.stage = ST_RELEASE;
        end
      end
      default: begin
        if (cur.stage != ST_IDLE) begin
          nxt.stage = ST_RELEASE;
        end
      end
    endcase
  end

endmodule
